// ----- rtl/core/bpo3_pkg.sv -----
// ----------------------------------------------------------------------------
// bpo3_pkg
// Shared widths, register codes and beat types of the block partition owner.
// ----------------------------------------------------------------------------
package bpo3_pkg;

  localparam int SUB_W    = 10;
  localparam int GRID_W   = 11;
  localparam int PARTS_W  = 5;
  localparam int OWNER_W  = 12;
  localparam int IDX_W    = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int DEF_MAX_GRID  = 1024;
  localparam int DEF_MAX_PARTS = 16;

  // divider: one zero bit on top of the grid size, DIV_STEPS quotient bits per stage
  localparam int DIV_W      = GRID_W + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  localparam int AXIS_LAT = DIV_STAGES + 2;
  localparam int PIPE_LAT = AXIS_LAT + 2;

  localparam logic [2:0] REG_GRID_X  = 3'd0;
  localparam logic [2:0] REG_GRID_Y  = 3'd1;
  localparam logic [2:0] REG_GRID_Z  = 3'd2;
  localparam logic [2:0] REG_PARTS_X = 3'd3;
  localparam logic [2:0] REG_PARTS_Y = 3'd4;
  localparam logic [2:0] REG_PARTS_Z = 3'd5;

  typedef struct packed {
    logic [SUB_W-1:0] sub_x;
    logic [SUB_W-1:0] sub_y;
    logic [SUB_W-1:0] sub_z;
  } in_item_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic               in_range;
  } out_item_t;

endpackage

// ----- rtl/core/bpo3_axis.sv -----
// ----------------------------------------------------------------------------
// bpo3_axis
// Part index of one subscript along one axis: pipelined n/p division, then
// a compare against every part start and a count of the starts passed.
// ----------------------------------------------------------------------------
module bpo3_axis #(
  parameter int MAX_PARTS = bpo3_pkg::DEF_MAX_PARTS,
  parameter bit BACK      = 1'b0
) (
  input  logic                          clk,
  input  logic [bpo3_pkg::SUB_W-1:0]    s_i,
  input  logic [bpo3_pkg::GRID_W-1:0]   n_i,
  input  logic [bpo3_pkg::PARTS_W-1:0]  p_i,
  output logic [bpo3_pkg::IDX_W-1:0]    idx_o,
  output logic                          inr_o
);

  localparam int NL   = (MAX_PARTS < 31) ? MAX_PARTS : 31;
  localparam int NS   = bpo3_pkg::DIV_STAGES;
  localparam int DW   = bpo3_pkg::DIV_W;
  localparam int PW   = bpo3_pkg::PARTS_W;
  localparam int ST_W = 16;

  logic [DW-1:0]              dvd_src [0:NS-1];
  logic [PW-1:0]              rem_src [0:NS-1];
  logic [DW-1:0]              quo_src [0:NS-1];
  logic [DW-1:0]              dvd_r   [1:NS];
  logic [PW-1:0]              rem_r   [1:NS];
  logic [DW-1:0]              quo_r   [1:NS];
  logic [bpo3_pkg::SUB_W-1:0] s_r     [1:NS];
  logic                       inr_r   [1:NS];
  logic [NL:1]                ge_r;
  logic [bpo3_pkg::SUB_W-1:0] unused_s;
  logic                       inr_c_r;
  logic [bpo3_pkg::IDX_W-1:0] idx_r;
  logic                       inr_o_r;

  assign dvd_src[0] = {1'b0, n_i};
  assign rem_src[0] = '0;
  assign quo_src[0] = '0;
  assign unused_s   = s_r[NS];

  genvar st;
  generate
    for (st = 1; st < NS; st++) begin : g_src
      assign dvd_src[st] = dvd_r[st];
      assign rem_src[st] = rem_r[st];
      assign quo_src[st] = quo_r[st];
    end

    for (st = 0; st < NS; st++) begin : g_div
      logic [DW-1:0] dvd_nxt;
      logic [PW-1:0] rem_nxt;
      logic [DW-1:0] quo_nxt;
      always_comb begin
        logic [PW:0] t;
        dvd_nxt = dvd_src[st];
        rem_nxt = rem_src[st];
        quo_nxt = quo_src[st];
        for (int k = 0; k < bpo3_pkg::DIV_STEPS; k++) begin
          t       = {rem_nxt, dvd_nxt[DW-1]};
          dvd_nxt = {dvd_nxt[DW-2:0], 1'b0};
          if (t >= {1'b0, p_i}) begin
            rem_nxt = PW'(t - {1'b0, p_i});
            quo_nxt = {quo_nxt[DW-2:0], 1'b1};
          end else begin
            rem_nxt = t[PW-1:0];
            quo_nxt = {quo_nxt[DW-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        dvd_r[st+1] <= dvd_nxt;
        rem_r[st+1] <= rem_nxt;
        quo_r[st+1] <= quo_nxt;
      end
    end

    for (st = 2; st <= NS; st++) begin : g_carry
      always_ff @(posedge clk) begin
        s_r[st]   <= s_r[st-1];
        inr_r[st] <= inr_r[st-1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    s_r[1]   <= s_i;
    inr_r[1] <= ({1'b0, s_i} < n_i);
  end

  // part start: i*q plus the leftover points handed out before part i
  always_ff @(posedge clk) begin
    logic [ST_W-1:0] start;
    logic [ST_W-1:0] adj;
    logic [PW-1:0]   pr;
    pr = p_i - rem_r[NS];
    for (int i = 1; i <= NL; i++) begin
      if (BACK) begin
        adj = (PW'(i) > pr) ? ST_W'(PW'(i) - pr) : '0;
      end else begin
        adj = (PW'(i) < rem_r[NS]) ? ST_W'(i) : ST_W'(rem_r[NS]);
      end
      start   = ST_W'(ST_W'(i) * ST_W'(quo_r[NS])) + adj;
      ge_r[i] <= (PW'(i) < p_i) && (start <= ST_W'(unused_s));
    end
    inr_c_r <= inr_r[NS];
  end

  always_ff @(posedge clk) begin
    logic [bpo3_pkg::IDX_W-1:0] cnt;
    cnt = '0;
    for (int i = 1; i <= NL; i++) begin
      cnt = cnt + bpo3_pkg::IDX_W'(ge_r[i]);
    end
    idx_r   <= cnt;
    inr_o_r <= inr_c_r;
  end

  assign idx_o = idx_r;
  assign inr_o = inr_o_r;

endmodule

// ----- rtl/core/block_partition_owner_3d.sv -----
// ----------------------------------------------------------------------------
// block_partition_owner_3d
// Owning partition of a 3D grid subscript under a block decomposition.
// ----------------------------------------------------------------------------
// One subscript is taken every clock (busy is low outside reset) and its
// result appears on out_item with out_valid after three divider stages per
// axis for n/p, a part-start compare, a count, and two multiply stages to
// fold the axis indices into the owner number. Results cannot be held off;
// the grid and part registers must stay unchanged while beats are in flight.
module block_partition_owner_3d #(
  parameter int MAX_GRID  = bpo3_pkg::DEF_MAX_GRID,
  parameter int MAX_PARTS = bpo3_pkg::DEF_MAX_PARTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bpo3_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output bpo3_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpo3_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpo3_pkg::DATA_W-1:0]   pwdata,
  output logic [bpo3_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int GW = bpo3_pkg::GRID_W;
  localparam int PW = bpo3_pkg::PARTS_W;
  localparam int OW = bpo3_pkg::OWNER_W;
  localparam int IW = bpo3_pkg::IDX_W;
  localparam int PL = bpo3_pkg::PIPE_LAT;

  logic [GW-1:0] grid_x_r, grid_y_r, grid_z_r;
  logic [PW-1:0] parts_x_r, parts_y_r, parts_z_r;
  logic [GW-1:0] nx, ny, nz;
  logic [PW-1:0] px, py, pz;
  logic [2:0]    reg_idx;
  logic          wr_en;

  logic [PL-1:0] vld_r;
  logic [IW-1:0] ix, jy, kz;
  logic          inr_x, inr_y, inr_z;
  logic [OW-1:0] m1_r;
  logic [IW-1:0] kz_r;
  logic          inr6_r;
  logic [OW-1:0] owner_r;
  logic          inr_out_r;

  function automatic logic [GW-1:0] clamp_grid(input logic [GW-1:0] n);
    return (32'(n) > MAX_GRID) ? GW'(MAX_GRID) : n;
  endfunction

  function automatic logic [PW-1:0] clamp_parts(input logic [PW-1:0] p);
    if (p == '0) return PW'(1);
    return (32'(p) > MAX_PARTS) ? PW'(MAX_PARTS) : p;
  endfunction

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r  <= GW'(1);
      grid_y_r  <= GW'(1);
      grid_z_r  <= GW'(1);
      parts_x_r <= PW'(1);
      parts_y_r <= PW'(1);
      parts_z_r <= PW'(1);
    end else if (wr_en) begin
      case (reg_idx)
        bpo3_pkg::REG_GRID_X:  grid_x_r  <= pwdata[GW-1:0];
        bpo3_pkg::REG_GRID_Y:  grid_y_r  <= pwdata[GW-1:0];
        bpo3_pkg::REG_GRID_Z:  grid_z_r  <= pwdata[GW-1:0];
        bpo3_pkg::REG_PARTS_X: parts_x_r <= pwdata[PW-1:0];
        bpo3_pkg::REG_PARTS_Y: parts_y_r <= pwdata[PW-1:0];
        bpo3_pkg::REG_PARTS_Z: parts_z_r <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpo3_pkg::REG_GRID_X:  prdata = 32'(grid_x_r);
      bpo3_pkg::REG_GRID_Y:  prdata = 32'(grid_y_r);
      bpo3_pkg::REG_GRID_Z:  prdata = 32'(grid_z_r);
      bpo3_pkg::REG_PARTS_X: prdata = 32'(parts_x_r);
      bpo3_pkg::REG_PARTS_Y: prdata = 32'(parts_y_r);
      bpo3_pkg::REG_PARTS_Z: prdata = 32'(parts_z_r);
      default:               prdata = '0;
    endcase
  end

  assign nx = clamp_grid(grid_x_r);
  assign ny = clamp_grid(grid_y_r);
  assign nz = clamp_grid(grid_z_r);
  assign px = clamp_parts(parts_x_r);
  assign py = clamp_parts(parts_y_r);
  assign pz = clamp_parts(parts_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PL-2:0], start && !busy};
    end
  end

  // leftovers to the first parts on x and z, to the last parts on y
  bpo3_axis #(.MAX_PARTS(MAX_PARTS), .BACK(1'b0)) u_axis_x (
    .clk(clk), .s_i(in_item.sub_x), .n_i(nx), .p_i(px), .idx_o(ix), .inr_o(inr_x)
  );
  bpo3_axis #(.MAX_PARTS(MAX_PARTS), .BACK(1'b1)) u_axis_y (
    .clk(clk), .s_i(in_item.sub_y), .n_i(ny), .p_i(py), .idx_o(jy), .inr_o(inr_y)
  );
  bpo3_axis #(.MAX_PARTS(MAX_PARTS), .BACK(1'b0)) u_axis_z (
    .clk(clk), .s_i(in_item.sub_z), .n_i(nz), .p_i(pz), .idx_o(kz), .inr_o(inr_z)
  );

  always_ff @(posedge clk) begin
    m1_r   <= OW'(OW'(ix) * OW'(py)) + OW'(jy);
    kz_r   <= kz;
    inr6_r <= inr_x && inr_y && inr_z;
  end

  always_ff @(posedge clk) begin
    owner_r   <= inr6_r ? OW'(OW'(m1_r * OW'(pz)) + OW'(kz_r)) : '0;
    inr_out_r <= inr6_r;
  end

  assign out_valid         = vld_r[PL-1];
  assign out_item.owner    = owner_r;
  assign out_item.in_range = inr_out_r;

endmodule

// ----- rtl/core/bpo3_checker.sv -----
// ----------------------------------------------------------------------------
// bpo3_checker
// Port-level checks of the block partition owner, bound to the top level.
// ----------------------------------------------------------------------------
module bpo3_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bpo3_pkg::out_item_t out_item,
  input logic                pready
);

  localparam int PL = bpo3_pkg::PIPE_LAT;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PL out_valid)
    else $error("accepted beat not answered after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PL))
    else $error("result beat without matching accepted beat");

  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.in_range) |-> (out_item.owner == '0))
    else $error("out of range result carries nonzero owner");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind block_partition_owner_3d bpo3_checker u_bpo3_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item), .pready(pready)
);
